/* rtl/psfu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfu_pkg: shared types and constants
// Constants, config bundle and result bundle used by the parser modules.
// ----------------------------------------------------------------------------
package psfu_pkg;

  localparam logic [16:0] MAX_GLYPHS      = 17'd65536;
  localparam logic [16:0] GLYPH_COUNT_RST = 17'd256;

  localparam logic [7:0]  SEQ_START_BYTE  = 8'hFE;
  localparam logic [7:0]  TERM_BYTE       = 8'hFF;
  localparam logic [15:0] SEQ_START_UNIT  = 16'hFFFE;
  localparam logic [15:0] TERM_UNIT       = 16'hFFFF;

  localparam logic REG_UTF8_MODE   = 1'b0;
  localparam logic REG_GLYPH_COUNT = 1'b1;

  typedef struct packed {
    logic        utf8_mode;
    logic [16:0] glyph_count;
    logic        mode_wr;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] glyph;
    logic [31:0] code0;
    logic [31:0] code1;
  } res_t;

  typedef struct packed {
    logic        last;
    logic [31:0] code;
    logic [15:0] glyph;
  } out_ent_t;

endpackage

/* rtl/psf_unicode_table_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_unicode_table_parser: font unicode table decoder, top level
// A byte's first word passes through the input register and the result queue.
// Throughput: one byte per cycle while the result queue has space; a byte
//   giving two words takes two entries of the 4-entry result queue.
// Reset: utf8_mode = 1, glyph_count = 256, parser in plain list phase,
//   glyph counter zero, input register and result queue empty.
// ----------------------------------------------------------------------------
module psf_unicode_table_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] table_byte
  input  logic        in_tlast,    // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] glyph_index, [47:16] code_point
  output logic        out_tlast,   // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import psfu_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eod_r;
  logic       space;
  logic       advance;

  assign advance   = in_valid_r && space;
  assign in_tready = !in_valid_r || space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eod_r  <= in_tlast;
    end
  end

  psfu_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  psfu_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .byte_i (in_byte_r),
    .eod_i  (in_eod_r),
    .cfg    (cfg),
    .res    (res)
  );

  psfu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .space_o    (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/psfu_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfu_regs: configuration registers
// APB-style register file holding the table mode and the glyph count.
// ----------------------------------------------------------------------------
module psfu_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output psfu_pkg::cfg_t   cfg
);
  import psfu_pkg::*;

  logic        utf8_mode_r;
  logic [16:0] glyph_count_r;
  logic        wr;
  logic        idx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_mode_r   <= 1'b1;
      glyph_count_r <= GLYPH_COUNT_RST;
    end else if (wr) begin
      case (idx)
        REG_UTF8_MODE:   utf8_mode_r   <= cfg_pwdata[0];
        REG_GLYPH_COUNT: glyph_count_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UTF8_MODE:   cfg_prdata = {31'd0, utf8_mode_r};
      REG_GLYPH_COUNT: cfg_prdata = {15'd0, glyph_count_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.utf8_mode   = utf8_mode_r;
  assign cfg.glyph_count = glyph_count_r;
  assign cfg.mode_wr     = wr && (idx == REG_UTF8_MODE);

endmodule

/* rtl/psfu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfu_core: table byte decoder
// Parser state and single-pass decode of one table byte into up to two results.
// ----------------------------------------------------------------------------
module psfu_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             eod_i,
  input  psfu_pkg::cfg_t   cfg,
  output psfu_pkg::res_t   res
);
  import psfu_pkg::*;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'b01,
    PH_SEQ   = 2'b10
  } phase_t;

  typedef struct packed {
    phase_t      ph;
    logic [1:0]  cnt;
    logic [31:0] held;
    logic [31:0] pend;
    logic        pv;
    logic [7:0]  lo;
    logic        lov;
    logic [16:0] ctr;
    logic [1:0]  n;
    logic [31:0] e0;
    logic [31:0] e1;
  } work_t;

  phase_t      ph_r;
  logic [1:0]  cnt_r;
  logic [31:0] held_r;
  logic [31:0] pend_r;
  logic        pv_r;
  logic [7:0]  lo_r;
  logic        lov_r;
  logic [16:0] ctr_r;

  work_t       w_nxt;
  logic [16:0] limit;
  logic        active;
  logic [15:0] unit;
  logic [31:0] lead;

  function automatic work_t f_emit(work_t w, logic [31:0] code);
    if (w.n == 2'd0) begin
      w.e0 = code;
      w.n  = 2'd1;
    end else if (w.n == 2'd1) begin
      w.e1 = code;
      w.n  = 2'd2;
    end
    return w;
  endfunction

  function automatic work_t f_deliver(work_t w, logic [31:0] code);
    if (w.ph == PH_PLAIN) begin
      w = f_emit(w, code);
    end else begin
      if (w.cnt == 2'd0) w.held = code;
      if (w.cnt != 2'd2) w.cnt = w.cnt + 2'd1;
    end
    return w;
  endfunction

  function automatic work_t f_close(work_t w);
    if (w.ph == PH_SEQ && w.cnt == 2'd1) w = f_emit(w, w.held);
    w.cnt  = 2'd0;
    w.held = 32'd0;
    return w;
  endfunction

  function automatic work_t f_marker(work_t w, logic is_term);
    if (!is_term) begin
      if (w.ph == PH_SEQ) w = f_close(w);
      w.ph  = PH_SEQ;
      w.cnt = 2'd0;
    end else begin
      w     = f_close(w);
      w.ph  = PH_PLAIN;
      w.ctr = w.ctr + 17'd1;
    end
    return w;
  endfunction

  function automatic work_t f_flush(work_t w);
    if (w.pv) begin
      w.pv   = 1'b0;
      w      = f_deliver(w, w.pend);
      w.pend = 32'd0;
    end
    return w;
  endfunction

  assign limit  = (cfg.glyph_count > MAX_GLYPHS) ? MAX_GLYPHS : cfg.glyph_count;
  assign active = ctr_r < limit;
  assign unit   = {byte_i, lo_r};

  always_comb begin
    if (byte_i[7:3] == 5'b11110)     lead = {29'd0, byte_i[2:0]};
    else if (byte_i[7:4] == 4'b1110) lead = {28'd0, byte_i[3:0]};
    else if (byte_i[7:5] == 3'b110)  lead = {27'd0, byte_i[4:0]};
    else                             lead = {25'd0, byte_i[6:0]};
  end

  always_comb begin
    w_nxt = '{ph: ph_r, cnt: cnt_r, held: held_r, pend: pend_r, pv: pv_r,
               lo: lo_r, lov: lov_r, ctr: ctr_r, n: 2'd0, e0: 32'd0, e1: 32'd0};
    if (active) begin
      if (cfg.utf8_mode) begin
        if (byte_i == SEQ_START_BYTE || byte_i == TERM_BYTE) begin
          w_nxt = f_flush(w_nxt);
          w_nxt = f_marker(w_nxt, byte_i == TERM_BYTE);
        end else if (w_nxt.pv && byte_i[7:6] == 2'b10) begin
          w_nxt.pend = {w_nxt.pend[25:0], byte_i[5:0]};
        end else begin
          w_nxt = f_flush(w_nxt);
          if (!byte_i[7]) begin
            w_nxt = f_deliver(w_nxt, {24'd0, byte_i});
          end else begin
            w_nxt.pend = lead;
            w_nxt.pv   = 1'b1;
          end
        end
      end else if (!w_nxt.lov) begin
        w_nxt.lo  = byte_i;
        w_nxt.lov = 1'b1;
      end else begin
        w_nxt.lov = 1'b0;
        w_nxt.lo  = 8'd0;
        if (unit == SEQ_START_UNIT)  w_nxt = f_marker(w_nxt, 1'b0);
        else if (unit == TERM_UNIT)  w_nxt = f_marker(w_nxt, 1'b1);
        else                         w_nxt = f_deliver(w_nxt, {16'd0, unit});
      end
    end
    if (eod_i) begin
      if (w_nxt.pv && w_nxt.ph == PH_PLAIN && active) w_nxt = f_flush(w_nxt);
      w_nxt.ph   = PH_PLAIN;
      w_nxt.cnt  = 2'd0;
      w_nxt.held = 32'd0;
      w_nxt.pend = 32'd0;
      w_nxt.pv   = 1'b0;
      w_nxt.lo   = 8'd0;
      w_nxt.lov  = 1'b0;
      w_nxt.ctr  = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_PLAIN;
      cnt_r  <= 2'd0;
      held_r <= 32'd0;
      pend_r <= 32'd0;
      pv_r   <= 1'b0;
      lo_r   <= 8'd0;
      lov_r  <= 1'b0;
      ctr_r  <= 17'd0;
    end else if (step_i) begin
      ph_r   <= w_nxt.ph;
      cnt_r  <= w_nxt.cnt;
      held_r <= w_nxt.held;
      pend_r <= w_nxt.pend;
      pv_r   <= w_nxt.pv;
      lo_r   <= w_nxt.lo;
      lov_r  <= w_nxt.lov;
      ctr_r  <= w_nxt.ctr;
    end else if (cfg.mode_wr) begin
      pend_r <= 32'd0;
      pv_r   <= 1'b0;
      lo_r   <= 8'd0;
      lov_r  <= 1'b0;
    end
  end

  assign res.n     = step_i ? w_nxt.n : 2'd0;
  assign res.glyph = ctr_r[15:0];
  assign res.code0 = w_nxt.e0;
  assign res.code1 = w_nxt.e1;

endmodule

/* rtl/psfu_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfu_outq: result queue
// Four-entry shift queue taking up to two words a cycle, draining one a cycle while out_tready is high.
// ----------------------------------------------------------------------------
module psfu_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  psfu_pkg::res_t   res,
  output logic             space_o,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tlast
);
  import psfu_pkg::*;

  out_ent_t   q_r   [4];
  out_ent_t   q_nxt [4];
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic [2:0] base;
  logic       pop;
  out_ent_t   r0;
  out_ent_t   r1;

  assign out_tvalid = count_r != 3'd0;
  assign pop        = out_tvalid && out_tready;
  assign base       = count_r - {2'd0, pop};
  assign space_o    = count_r <= 3'd2;
  assign count_nxt  = base + {1'b0, res.n};

  assign r0 = '{last: res.n == 2'd1, code: res.code0, glyph: res.glyph};
  assign r1 = '{last: 1'b1, code: res.code1, glyph: res.glyph};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[3] = q_r[3];
    for (int i = 0; i < 4; i++) begin
      if (res.n != 2'd0 && base[1:0] == 2'(i)) q_nxt[i] = r0;
      if (res.n == 2'd2 && (base[1:0] + 2'd1) == 2'(i)) q_nxt[i] = r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tdata = {q_r[0].code, q_r[0].glyph};
  assign out_tlast = q_r[0].last;

endmodule
